/* hw/rtl/sga_pkg.sv */
// Shared types and constants for the SiLU/GELU activation pipeline.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sga_pkg;

  localparam int SAMPLE_W = 24;  // Q8.16 sample width, both directions
  localparam int MAG_W    = 24;  // magnitude of a sample, holds 2^23
  localparam int GATE_W   = 31;  // gate value, unsigned Q1.30, at most 1.0
  localparam int GATE_FRAC = 30;

  localparam logic [GATE_W-1:0] GATE_ONE = GATE_W'(1) << GATE_FRAC;

  // Log2 of the table span in units of x: sigmoid covers 0..16, Phi 0..8
  localparam int SIG_SPAN_LOG2 = 4;
  localparam int PHI_SPAN_LOG2 = 3;

  typedef enum logic {
    MODE_SILU = 1'b0,
    MODE_GELU = 1'b1
  } sga_mode_t;

  // Per-item control that rides along each pipeline stage
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             sat;
    sga_mode_t        mode;
    logic [MAG_W-1:0] mag;
  } sga_ctl_t;

endpackage

/* hw/rtl/silu_gelu_activation_core.sv */
// Top level of the SiLU/GELU activation core: stage 1 locate, stage 2 ROM,
// stages 3-4 interpolation, stages 5-6 gate product and sign. Depends on sga_pkg
// and the sga_locate, sga_gate_rom and sga_interp modules.
//
//   channel  | ports                                | transfer when
//   ---------+--------------------------------------+-----------------------------
//   input    | start, busy, in_sample_in            | start && !busy
//   result   | out_valid, out_sample_out            | out_valid (one cycle)
//   config   | cfg_valid, cfg_ready, cfg_activation_mode | cfg_valid && cfg_ready
//
// One sample per cycle while busy is low, results in order.
// The six register stages are locate, ROM read, weighted
// difference, gate, gate product, sign.
// Synchronous reset clears all valid bits and the mode (SiLU); busy is high
// only while reset is applied or in the cycle after it.
// The pipeline never stalls: the receiver takes every result.
`timescale 1ns / 1ps

module silu_gelu_activation_core import sga_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAC_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_sample_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_activation_mode
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FR_W   = FRAC_BITS + SIG_SPAN_LOG2;
  localparam int FULL_W = MAG_W + GATE_W;

  logic                busy_r;
  sga_mode_t           mode_r;
  logic                take;

  sga_ctl_t            ctl1;
  logic [IDX_W-1:0]    idx1;
  logic [FR_W-1:0]     fr1;
  sga_ctl_t            ctl2;
  logic [FR_W-1:0]     fr2;
  logic [GATE_W-1:0]   lo2;
  logic [GATE_W-1:0]   hi2;
  sga_ctl_t            ctl4;
  logic [GATE_W-1:0]   gate4;

  logic [FULL_W-1:0]   full;
  logic [MAG_W-1:0]    res_mag_nxt;
  logic [MAG_W-1:0]    res_mag_r;
  logic [MAG_W-1:0]    mag5_r;
  logic                neg5_r;
  logic                valid5_r;
  logic [SAMPLE_W-1:0] out_nxt;
  logic [SAMPLE_W-1:0] out_r;
  logic                out_valid_r;

  assign busy      = busy_r | ~rst_n;
  assign cfg_ready = ~busy;
  assign take      = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      mode_r <= MODE_SILU;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mode_r <= sga_mode_t'(cfg_activation_mode);
      end
    end
  end

  sga_locate #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_locate (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .sample(in_sample_in),
    .mode  (mode_r),
    .ctl_o (ctl1),
    .idx_o (idx1),
    .fr_o  (fr1)
  );

  sga_gate_rom #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_rom (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl_i(ctl1),
    .idx_i(idx1),
    .fr_i (fr1),
    .ctl_o(ctl2),
    .fr_o (fr2),
    .lo_o (lo2),
    .hi_o (hi2)
  );

  sga_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl2),
    .fr_i  (fr2),
    .lo_i  (lo2),
    .hi_i  (hi2),
    .ctl_o (ctl4),
    .gate_o(gate4)
  );

  // Stage 5: |y| = (|x| * g + half) >> 30, rounds half away from zero
  always_comb begin
    full        = FULL_W'(ctl4.mag) * FULL_W'(gate4) + (FULL_W'(1) << (GATE_FRAC - 1));
    res_mag_nxt = full[GATE_FRAC+MAG_W-1:GATE_FRAC];
  end

  // Stage 6: reapply the sign
  assign out_nxt = neg5_r ? SAMPLE_W'(~res_mag_r + MAG_W'(1)) : SAMPLE_W'(res_mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid5_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid5_r    <= ctl4.valid;
      out_valid_r <= valid5_r;
    end
    res_mag_r <= res_mag_nxt;
    mag5_r    <= ctl4.mag;
    neg5_r    <= ctl4.neg;
    out_r     <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

`ifndef SYNTHESIS
  a_mag_not_grown: assert property (@(posedge clk) disable iff (!rst_n)
    valid5_r |-> res_mag_r <= mag5_r)
    else $error("activation magnitude exceeds input magnitude");

  a_sign_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_out[SAMPLE_W-1] |-> $past(neg5_r))
    else $error("negative result from nonnegative sample");

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_valid == $past(valid5_r))
    else $error("result strobe out of step with pipeline");
`endif

endmodule

/* hw/rtl/sga_locate.sv */
// Stage 1: takes the magnitude of the sample and finds the table index and
// interpolation fraction. Depends on sga_pkg.
`timescale 1ns / 1ps

module sga_locate import sga_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAC_BITS     = 16,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int FR_W  = FRAC_BITS + SIG_SPAN_LOG2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [SAMPLE_W-1:0] sample,
  input  sga_mode_t           mode,
  output sga_ctl_t            ctl_o,
  output logic [IDX_W-1:0]    idx_o,
  output logic [FR_W-1:0]     fr_o
);

  localparam int POS_W = MAG_W + $clog2(TABLE_ENTRIES + 1);

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] idx_full;
  sga_ctl_t         ctl_nxt;
  sga_ctl_t         ctl_r;
  logic [IDX_W-1:0] idx_r;
  logic [FR_W-1:0]  fr_r;
  logic [FR_W-1:0]  fr_nxt;

  always_comb begin
    neg = sample[SAMPLE_W-1];
    // the most negative code maps onto magnitude 2^23 exactly
    mag = neg ? MAG_W'(~sample + SAMPLE_W'(1)) : MAG_W'(sample);
    pos = POS_W'(mag) * POS_W'(TABLE_ENTRIES);
    if (mode == MODE_GELU) begin
      idx_full = pos >> (FRAC_BITS + PHI_SPAN_LOG2);
      fr_nxt   = FR_W'(pos[FRAC_BITS+PHI_SPAN_LOG2-1:0]);
    end else begin
      idx_full = pos >> (FRAC_BITS + SIG_SPAN_LOG2);
      fr_nxt   = pos[FR_W-1:0];
    end
    ctl_nxt.valid = take;
    ctl_nxt.neg   = neg;
    ctl_nxt.sat   = (idx_full >= POS_W'(TABLE_ENTRIES));
    ctl_nxt.mode  = mode;
    ctl_nxt.mag   = mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.neg  <= ctl_nxt.neg;
    ctl_r.sat  <= ctl_nxt.sat;
    ctl_r.mode <= ctl_nxt.mode;
    ctl_r.mag  <= ctl_nxt.mag;
    idx_r      <= idx_full[IDX_W-1:0];
    fr_r       <= fr_nxt;
  end

  assign ctl_o = ctl_r;
  assign idx_o = idx_r;
  assign fr_o  = fr_r;

endmodule

/* hw/rtl/sga_gate_rom.sv */
// Stage 2: gate ROM (sigmoid and Phi) with two registered read ports for
// the interpolation neighbors. Contents are built at elaboration. Depends on sga_pkg.
`timescale 1ns / 1ps

module sga_gate_rom import sga_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAC_BITS     = 16,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int FR_W  = FRAC_BITS + SIG_SPAN_LOG2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sga_ctl_t          ctl_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [FR_W-1:0]   fr_i,
  output sga_ctl_t          ctl_o,
  output logic [FR_W-1:0]   fr_o,
  output logic [GATE_W-1:0] lo_o,
  output logic [GATE_W-1:0] hi_o
);

  localparam int ROM_DEPTH = 2 * TABLE_ENTRIES + 2;
  localparam int ADDR_W    = $clog2(ROM_DEPTH);
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  typedef logic [ROM_DEPTH-1:0][GATE_W-1:0] rom_t;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return wide[125:62];
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, only used for ROM contents
  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] quo;
    int          i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid rows at 0..N, Phi rows at N+1..2N+1, unsigned Q1.30
  function automatic rom_t build_rom();
    logic [63:0] steps [3];
    logic [63:0] area [TABLE_ENTRIES+1];
    logic [63:0] num, den, term, sum, p, d, q, m, val, acc, top, f0, f1, f2, quo;
    int          c, n, k, j, s;
    rom_t        r;
    r = '0;
    // exp(-16/N), exp(-1/N^2), exp(-1/(2N^2)) by Taylor series
    for (c = 0; c < 3; c++) begin
      num = (c == 0) ? 64'd16 : 64'd1;
      den = (c == 0) ? 64'(TABLE_ENTRIES) :
            (c == 1) ? 64'(TABLE_ENTRIES) * 64'(TABLE_ENTRIES) :
                       64'd2 * 64'(TABLE_ENTRIES) * 64'(TABLE_ENTRIES);
      term = ONE_Q62;
      sum  = ONE_Q62;
      for (n = 1; n < 64 && term != 64'd0; n++) begin
        term = div_u64(term, den * 64'(n)) * num;
        if (n[0]) sum = sum - term;
        else      sum = sum + term;
      end
      steps[c] = sum;
    end
    // sigmoid = 1 / (1 + exp(-x))
    p = ONE_Q62;
    for (k = 0; k <= TABLE_ENTRIES; k++) begin
      d    = (ONE_Q62 + p) >> 32;
      quo  = div_u64((64'd1 << 60) + (d >> 1), d);
      r[k] = GATE_W'(quo[31:0]);
      p    = mul_q62(p, steps[0]);
    end
    // Phi by Simpson integration of exp(-t^2/2), eight sub-steps per entry
    q   = steps[1];
    m   = steps[2];
    val = ONE_Q62;
    acc = 64'd0;
    area[0] = 64'd0;
    for (j = 0; j < 8 * TABLE_ENTRIES; j += 2) begin
      f0  = val;
      val = mul_q62(val, m);
      m   = mul_q62(m, q);
      f1  = val;
      val = mul_q62(val, m);
      m   = mul_q62(m, q);
      f2  = val;
      acc = acc + (f0 >> 20) + 64'd4 * (f1 >> 20) + (f2 >> 20);
      if (((j + 2) & 7) == 0) area[(j + 2) >> 3] = acc;
    end
    top = area[TABLE_ENTRIES];
    s = 0;
    while (s < 40 && (top >> s) >= (64'd1 << 33)) s++;
    den = top >> s;
    if (den == 64'd0) den = 64'd1;
    for (k = 0; k <= TABLE_ENTRIES; k++) begin
      quo = (64'd1 << 29) + div_u64(((area[k] >> s) << 29) + (den >> 1), den);
      r[k + TABLE_ENTRIES + 1] = GATE_W'(quo[31:0]);
    end
    return r;
  endfunction

  localparam rom_t GATE_ROM = build_rom();

  logic [ADDR_W-1:0] addr_lo;
  logic [ADDR_W-1:0] addr_hi;
  sga_ctl_t          ctl_r;
  logic [FR_W-1:0]   fr_r;
  logic [GATE_W-1:0] lo_r;
  logic [GATE_W-1:0] hi_r;

  always_comb begin
    addr_lo = (ctl_i.mode == MODE_GELU) ?
              ADDR_W'(idx_i) + ADDR_W'(TABLE_ENTRIES + 1) : ADDR_W'(idx_i);
    addr_hi = addr_lo + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.neg  <= ctl_i.neg;
    ctl_r.sat  <= ctl_i.sat;
    ctl_r.mode <= ctl_i.mode;
    ctl_r.mag  <= ctl_i.mag;
    fr_r       <= fr_i;
    lo_r       <= GATE_ROM[addr_lo];
    hi_r       <= GATE_ROM[addr_hi];
  end

  assign ctl_o = ctl_r;
  assign fr_o  = fr_r;
  assign lo_o  = lo_r;
  assign hi_o  = hi_r;

endmodule

/* hw/rtl/sga_interp.sv */
// Stages 3 and 4: linear interpolation between ROM neighbors, clamp,
// saturation outside the span and mirroring for negative x. Depends on sga_pkg.
`timescale 1ns / 1ps

module sga_interp import sga_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int FR_W = FRAC_BITS + SIG_SPAN_LOG2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sga_ctl_t          ctl_i,
  input  logic [FR_W-1:0]   fr_i,
  input  logic [GATE_W-1:0] lo_i,
  input  logic [GATE_W-1:0] hi_i,
  output sga_ctl_t          ctl_o,
  output logic [GATE_W-1:0] gate_o
);

  localparam int PROD_W = GATE_W + FR_W + 1;

  logic [GATE_W-1:0] diff;
  logic [PROD_W-1:0] rnd;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [GATE_W-1:0] lo_r;
  sga_ctl_t          ctl3_r;
  logic [PROD_W-1:0] step;
  logic [GATE_W:0]   gsum;
  logic [GATE_W-1:0] gate;
  logic [GATE_W-1:0] gate_nxt;
  logic [GATE_W-1:0] gate_r;
  sga_ctl_t          ctl4_r;

  // Stage 3: weighted difference plus the half-LSB rounding term
  always_comb begin
    diff = hi_i - lo_i;
    rnd  = (ctl_i.mode == MODE_GELU) ? PROD_W'(1) << (FRAC_BITS + PHI_SPAN_LOG2 - 1)
                                     : PROD_W'(1) << (FRAC_BITS + SIG_SPAN_LOG2 - 1);
    prod_nxt = PROD_W'(diff) * PROD_W'(fr_i) + rnd;
  end

  // Stage 4: scale back, add the base entry, clamp at 1.0, mirror
  always_comb begin
    step = (ctl3_r.mode == MODE_GELU) ? prod_r >> (FRAC_BITS + PHI_SPAN_LOG2)
                                      : prod_r >> (FRAC_BITS + SIG_SPAN_LOG2);
    gsum = (GATE_W + 1)'(lo_r) + step[GATE_W:0];
    if (ctl3_r.sat || gsum > (GATE_W + 1)'(GATE_ONE)) begin
      gate = GATE_ONE;
    end else begin
      gate = gsum[GATE_W-1:0];
    end
    gate_nxt = ctl3_r.neg ? GATE_ONE - gate : gate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
      ctl4_r.valid <= 1'b0;
    end else begin
      ctl3_r.valid <= ctl_i.valid;
      ctl4_r.valid <= ctl3_r.valid;
    end
    ctl3_r.neg  <= ctl_i.neg;
    ctl3_r.sat  <= ctl_i.sat;
    ctl3_r.mode <= ctl_i.mode;
    ctl3_r.mag  <= ctl_i.mag;
    prod_r      <= prod_nxt;
    lo_r        <= lo_i;
    ctl4_r.neg  <= ctl3_r.neg;
    ctl4_r.sat  <= ctl3_r.sat;
    ctl4_r.mode <= ctl3_r.mode;
    ctl4_r.mag  <= ctl3_r.mag;
    gate_r      <= gate_nxt;
  end

  assign ctl_o  = ctl4_r;
  assign gate_o = gate_r;

`ifndef SYNTHESIS
  a_gate_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ctl4_r.valid |-> gate_r <= GATE_ONE)
    else $error("gate above full scale");

  a_sat_pos_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl4_r.valid && ctl4_r.sat && !ctl4_r.neg |-> gate_r == GATE_ONE)
    else $error("saturated positive sample lost full gate");

  a_sat_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl4_r.valid && ctl4_r.sat && ctl4_r.neg |-> gate_r == '0)
    else $error("saturated negative sample has nonzero gate");
`endif

endmodule
